>>> sv/scl_pkg.sv
// Shared types, character codes and helpers of the framed command link.
package scl_pkg;

    // Line characters
    localparam logic [7:0] CH_ACK     = 8'h06;
    localparam logic [7:0] CH_ENQ     = 8'h05;
    localparam logic [7:0] CH_STX     = 8'h02;
    localparam logic [7:0] CH_ETX     = 8'h03;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] NO_ADDR    = 8'hFF;

    // Register reset values
    localparam logic [7:0]  ADDR_RESET        = 8'hFF;
    localparam logic [7:0]  ADDR_TENS_RESET   = 8'h32;
    localparam logic [7:0]  ADDR_ONES_RESET   = 8'h35;
    localparam logic [15:0] ACK_WAIT_RESET    = 16'd500;
    localparam logic [15:0] REPLY_WAIT_RESET  = 16'd5000;
    localparam logic [15:0] GAP_WAIT_RESET    = 16'd50;
    localparam logic [15:0] WAIT_MAX          = 16'hFFFF;

    // Sizes
    localparam int MAX_RESULTS = 7;
    localparam int COUNT_W     = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        ACT_START,
        ACT_BODY,
        ACT_LINE,
        ACT_TICK
    } action_t;

    typedef enum logic [1:0] {
        KIND_TX,
        KIND_PAYLOAD,
        KIND_DONE
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_TIMEOUT,
        STATUS_PROTO
    } status_t;

    typedef enum logic [1:0] {
        REG_STATION_ADDRESS,
        REG_ACK_WAIT,
        REG_REPLY_WAIT,
        REG_GAP_WAIT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_ACK,
        PH_REPLY
    } phase_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  command_code;
        logic [7:0]  parameter_code;
        logic        has_body;
        logic [7:0]  reply_length;
        logic [7:0]  data_byte;
        logic        body_last;
    } in_word_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic        run_last;
        status_t     status;
    } out_word_t;

    // One result without its end mark
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        status_t     status;
    } res_word_t;

    // All results caused by one input word
    typedef struct packed {
        logic [COUNT_W-1:0]                count;
        res_word_t [MAX_RESULTS-1:0]       words;
    } job_t;

    function automatic res_word_t mk_word(kind_t k, logic [7:0] d, status_t s);
        res_word_t w;
        w.kind   = k;
        w.data   = d;
        w.status = s;
        return w;
    endfunction

    // ASCII tens and ones digits of an address; divide by ten via reciprocal
    function automatic logic [15:0] ascii_digits(logic [7:0] v);
        logic [15:0] prod;
        logic [7:0]  tens;
        logic [7:0]  ones;
        prod = {8'd0, v} * 16'd205;
        tens = {3'd0, prod[15:11]};
        ones = v - (tens << 3) - (tens << 1);
        return {tens + DIGIT_ZERO, ones + DIGIT_ZERO};
    endfunction

endpackage

>>> sv/scl_front.sv
// Front end: configuration registers, protocol state and result list per input word.
module scl_front
    import scl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wen,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_word_t                in_word,
    input  logic                    queue_full,
    output logic                    push,
    output job_t                    job
);

    // Configuration
    logic [7:0]  station_address_reg;
    logic [7:0]  addr_tens_reg;
    logic [7:0]  addr_ones_reg;
    logic [15:0] ack_wait_reg;
    logic [15:0] reply_wait_reg;
    logic [15:0] gap_wait_reg;

    // Protocol state
    phase_t      phase_reg, phase_next;
    logic [7:0]  check_reg, check_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [7:0]  reply_len_reg, reply_len_next;
    logic [15:0] wait_reg, wait_next;
    logic        ack_seen_reg, ack_seen_next;

    // Decode
    logic        accept;
    logic        addr_on;
    logic [7:0]  head_chk;
    logic [7:0]  body_chk;
    logic [8:0]  count_inc;
    logic [8:0]  ack_need;
    logic        ack_seen_now;
    logic [8:0]  hdr_len;
    logic [8:0]  total_len;
    logic [15:0] wait_inc;
    logic [15:0] wait_limit;
    logic        start_go, body_go, close_go;
    logic        line_ack, ack_complete, ack_fail, ack_done_ok, ack_to_reply;
    logic        line_reply, reply_end;
    logic        tick_live, timeout;
    logic        finish;
    logic [15:0] wdigits;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (job.count != '0);
    assign wdigits  = ascii_digits(cfg_data[7:0]);

    // Write configuration registers, digits worked out with the address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_address_reg <= ADDR_RESET;
            addr_tens_reg       <= ADDR_TENS_RESET;
            addr_ones_reg       <= ADDR_ONES_RESET;
            ack_wait_reg        <= ACK_WAIT_RESET;
            reply_wait_reg      <= REPLY_WAIT_RESET;
            gap_wait_reg        <= GAP_WAIT_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_STATION_ADDRESS:
                begin
                    station_address_reg <= cfg_data[7:0];
                    addr_tens_reg       <= wdigits[15:8];
                    addr_ones_reg       <= wdigits[7:0];
                end
                REG_ACK_WAIT:   ack_wait_reg   <= cfg_data;
                REG_REPLY_WAIT: reply_wait_reg <= cfg_data;
                REG_GAP_WAIT:   gap_wait_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Classify the incoming word
    always_comb
    begin
        addr_on      = station_address_reg != NO_ADDR;
        head_chk     = CH_STX ^ in_word.command_code ^ in_word.parameter_code
                       ^ (addr_on ? (addr_tens_reg ^ addr_ones_reg) : 8'd0);
        body_chk     = check_reg ^ in_word.data_byte;
        count_inc    = byte_count_reg + 9'd1;
        ack_need     = addr_on ? 9'd3 : 9'd1;
        ack_seen_now = (byte_count_reg == 9'd0) ? (in_word.data_byte == CH_ACK)
                                                 : ack_seen_reg;
        hdr_len      = addr_on ? 9'd5 : 9'd3;
        total_len    = {1'b0, reply_len_reg} + hdr_len + 9'd2;
        wait_inc     = (wait_reg == WAIT_MAX) ? wait_reg : wait_reg + 16'd1;
        if (byte_count_reg != 9'd0)
            wait_limit = gap_wait_reg;
        else if (phase_reg == PH_ACK)
            wait_limit = ack_wait_reg;
        else
            wait_limit = reply_wait_reg;

        start_go     = accept && in_word.action == ACT_START && phase_reg == PH_IDLE;
        body_go      = accept && in_word.action == ACT_BODY && phase_reg == PH_BODY;
        close_go     = (start_go && !in_word.has_body) || (body_go && in_word.body_last);
        line_ack     = accept && in_word.action == ACT_LINE && phase_reg == PH_ACK;
        ack_complete = line_ack && (count_inc >= ack_need);
        ack_fail     = ack_complete && !ack_seen_now;
        ack_done_ok  = ack_complete && ack_seen_now && reply_len_reg == 8'd0;
        ack_to_reply = ack_complete && ack_seen_now && reply_len_reg != 8'd0;
        line_reply   = accept && in_word.action == ACT_LINE && phase_reg == PH_REPLY;
        reply_end    = line_reply && (count_inc >= total_len);
        tick_live    = accept && in_word.action == ACT_TICK
                       && (phase_reg == PH_ACK || phase_reg == PH_REPLY);
        timeout      = tick_live && (wait_inc >= wait_limit);
        finish       = ack_fail || ack_done_ok || reply_end || timeout;
    end

    // Next phase
    always_comb
    begin
        priority if (finish)
            phase_next = PH_IDLE;
        else if (close_go)
            phase_next = PH_ACK;
        else if (start_go)
            phase_next = PH_BODY;
        else if (ack_to_reply)
            phase_next = PH_REPLY;
        else
            phase_next = phase_reg;
    end

    // Result list and datapath updates
    always_comb
    begin
        check_next      = check_reg;
        byte_count_next = byte_count_reg;
        reply_len_next  = reply_len_reg;
        wait_next       = wait_reg;
        ack_seen_next   = ack_seen_reg;
        job             = '0;

        if (start_go)
        begin
            reply_len_next  = in_word.reply_length;
            byte_count_next = 9'd0;
            wait_next       = 16'd0;
            if (in_word.has_body)
                check_next = head_chk;
            else
            begin
                check_next    = head_chk ^ CH_ETX;
                ack_seen_next = 1'b0;
            end
            job.words[0] = mk_word(KIND_TX, CH_STX, STATUS_OK);
            if (addr_on)
            begin
                job.words[1] = mk_word(KIND_TX, addr_tens_reg, STATUS_OK);
                job.words[2] = mk_word(KIND_TX, addr_ones_reg, STATUS_OK);
                job.words[3] = mk_word(KIND_TX, in_word.command_code, STATUS_OK);
                job.words[4] = mk_word(KIND_TX, in_word.parameter_code, STATUS_OK);
                job.words[5] = mk_word(KIND_TX, CH_ETX, STATUS_OK);
                job.words[6] = mk_word(KIND_TX, head_chk ^ CH_ETX, STATUS_OK);
                job.count    = in_word.has_body ? 3'd5 : 3'd7;
            end
            else
            begin
                job.words[1] = mk_word(KIND_TX, in_word.command_code, STATUS_OK);
                job.words[2] = mk_word(KIND_TX, in_word.parameter_code, STATUS_OK);
                job.words[3] = mk_word(KIND_TX, CH_ETX, STATUS_OK);
                job.words[4] = mk_word(KIND_TX, head_chk ^ CH_ETX, STATUS_OK);
                job.count    = in_word.has_body ? 3'd3 : 3'd5;
            end
        end
        else if (body_go)
        begin
            job.words[0] = mk_word(KIND_TX, in_word.data_byte, STATUS_OK);
            if (in_word.body_last)
            begin
                check_next      = body_chk ^ CH_ETX;
                byte_count_next = 9'd0;
                wait_next       = 16'd0;
                ack_seen_next   = 1'b0;
                job.words[1]    = mk_word(KIND_TX, CH_ETX, STATUS_OK);
                job.words[2]    = mk_word(KIND_TX, body_chk ^ CH_ETX, STATUS_OK);
                job.count       = 3'd3;
            end
            else
            begin
                check_next = body_chk;
                job.count  = 3'd1;
            end
        end
        else if (accept && in_word.action == ACT_LINE)
        begin
            wait_next = 16'd0;
            if (line_ack)
            begin
                byte_count_next = count_inc;
                ack_seen_next   = ack_seen_now;
                if (ack_fail)
                begin
                    byte_count_next = 9'd0;
                    job.words[0]    = mk_word(KIND_DONE, 8'd0, STATUS_PROTO);
                    job.count       = 3'd1;
                end
                else if (ack_complete)
                begin
                    byte_count_next = 9'd0;
                    check_next      = (reply_len_reg == 8'd0) ? check_reg : 8'd0;
                    job.words[0]    = mk_word(KIND_TX, CH_ENQ, STATUS_OK);
                    if (addr_on)
                    begin
                        job.words[1] = mk_word(KIND_TX, addr_tens_reg, STATUS_OK);
                        job.words[2] = mk_word(KIND_TX, addr_ones_reg, STATUS_OK);
                        job.words[3] = mk_word(KIND_DONE, 8'd0, STATUS_OK);
                        job.count    = ack_done_ok ? 3'd4 : 3'd3;
                    end
                    else
                    begin
                        job.words[1] = mk_word(KIND_DONE, 8'd0, STATUS_OK);
                        job.count    = ack_done_ok ? 3'd2 : 3'd1;
                    end
                end
            end
            else if (line_reply)
            begin
                if (reply_end)
                begin
                    byte_count_next = 9'd0;
                    job.words[0]    = mk_word(KIND_DONE, 8'd0,
                        (check_reg == in_word.data_byte) ? STATUS_OK : STATUS_PROTO);
                    job.count       = 3'd1;
                end
                else
                begin
                    check_next      = body_chk;
                    byte_count_next = count_inc;
                    if (byte_count_reg >= hdr_len
                        && byte_count_reg < hdr_len + {1'b0, reply_len_reg})
                    begin
                        job.words[0] = mk_word(KIND_PAYLOAD, in_word.data_byte, STATUS_OK);
                        job.count    = 3'd1;
                    end
                end
            end
        end
        else if (tick_live)
        begin
            wait_next = wait_inc;
            if (timeout)
            begin
                wait_next       = 16'd0;
                byte_count_next = 9'd0;
                job.words[0]    = mk_word(KIND_DONE, 8'd0, STATUS_TIMEOUT);
                job.count       = 3'd1;
            end
        end
    end

    // Hold protocol state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            check_reg      <= 8'd0;
            byte_count_reg <= 9'd0;
            reply_len_reg  <= 8'd0;
            wait_reg       <= 16'd0;
            ack_seen_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            check_reg      <= check_next;
            byte_count_reg <= byte_count_next;
            reply_len_reg  <= reply_len_next;
            wait_reg       <= wait_next;
            ack_seen_reg   <= ack_seen_next;
        end
    end

endmodule

>>> sv/scl_queue.sv
// Short queue of result lists between the front end and the output serializer.
module scl_queue
    import scl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = count_reg == '0;
    assign full     = count_reg == DEPTH_CNT;
    assign head_job = entries_reg[rd_ptr_reg];

    // Store pushed list
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/scl_back.sv
// Back end: walks each queued result list and drives the output register.
module scl_back
    import scl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head_job,
    input  logic      empty,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);

    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg;
    logic               load;
    logic               last_word;
    res_word_t          cur;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Pick the next word of the head list
    always_comb
    begin
        cur       = head_job.words[idx_reg];
        last_word = idx_reg == head_job.count - 1'b1;
        load      = !empty && (!out_valid_reg || out_ready);
        pop       = load && last_word;
        if (load)
            idx_next = last_word ? '0 : idx_reg + 1'b1;
        else
            idx_next = idx_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Load output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_word_reg.kind     <= cur.kind;
            out_word_reg.data     <= cur.data;
            out_word_reg.run_last <= last_word;
            out_word_reg.status   <= cur.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/stx_etx_bcc_command_link_top.sv
// Top level of the STX/ETX framed command link with ACK/ENQ handshake.
//
// Input channel (in_valid/in_ready/in_word): start, body byte, line byte or tick.
// Output channel (out_valid/out_ready/out_word): bytes to transmit, reply
// payload bytes for the host, and one completion word per job with its status.
// Configuration: cfg_wen writes cfg_data into register cfg_index at once
// (0 station address, 1 acknowledge wait, 2 reply wait, 3 byte gap wait).
// The front end takes one input word per cycle while the queue has room, and
// turns it into a list of up to seven result words for a two-entry queue.
// The back end sends one result word per cycle while the receiver is ready;
// each result passes through the queue entry and then the output register.
// The queue lets the front end take new input words while earlier results are
// still being sent, until it fills; the single output register sets the rate.
// When the receiver stalls, the output word holds, the queue fills and then
// in_ready drops; no word is lost. Reset clears the protocol state to idle,
// empties the queue and restores the register defaults (no address, 500,
// 5000 and 50 ticks).
module stx_etx_bcc_command_link_top
    import scl_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wen,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_word_t                in_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_word_t               out_word
);

    logic push;
    job_t push_job;
    job_t head_job;
    logic pop;
    logic empty;
    logic full;

    scl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .queue_full (full),
        .push       (push),
        .job        (push_job)
    );

    scl_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    scl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

>>> tb/command_link_checker.sv
// Checker for the command link: mirrors the link protocol and compares every output word.
module command_link_checker
    import scl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  in_word_t               in_word,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  out_word_t              out_word,
    output int                     mismatch_count,
    output int                     pending
);

    // Mirrored registers
    logic [7:0]  station;
    logic [15:0] ack_limit;
    logic [15:0] reply_limit;
    logic [15:0] gap_limit;

    // Mirrored protocol state
    phase_t      link_phase;
    logic [7:0]  frame_xor;
    logic [8:0]  rx_count;
    logic [7:0]  reply_len;
    logic [15:0] tick_count;
    logic        ack_ok;

    // Words the link still owes, oldest first
    out_word_t   due_words[$];
    int          bad;

    function automatic void push_word(kind_t k, logic [7:0] d, status_t s);
        out_word_t w;
        w.kind     = k;
        w.data     = d;
        w.run_last = 1'b0;
        w.status   = s;
        due_words.push_back(w);
    endfunction

    function automatic logic [7:0] tens_digit(logic [7:0] v);
        return v / 8'd10 + DIGIT_ZERO;
    endfunction

    function automatic logic [7:0] ones_digit(logic [7:0] v);
        return v % 8'd10 + DIGIT_ZERO;
    endfunction

    // Transmit a frame byte and fold it into the block check
    function automatic void send_byte(logic [7:0] b);
        frame_xor = frame_xor ^ b;
        push_word(KIND_TX, b, STATUS_OK);
    endfunction

    function automatic void end_job(status_t s);
        push_word(KIND_DONE, 8'h00, s);
        link_phase = PH_IDLE;
        tick_count = '0;
        rx_count   = '0;
    endfunction

    // Append ETX and the check byte, then wait for the acknowledge
    function automatic void close_frame();
        send_byte(CH_ETX);
        push_word(KIND_TX, frame_xor, STATUS_OK);
        link_phase = PH_ACK;
        rx_count   = '0;
        tick_count = '0;
        ack_ok     = 1'b0;
    endfunction

    function automatic void take_line_byte(logic [7:0] b);
        logic addr_on;
        int   need;
        int   hdr;
        int   total;
        addr_on    = (station != NO_ADDR);
        tick_count = '0;
        if (link_phase == PH_ACK)
        begin
            need = addr_on ? 3 : 1;
            if (rx_count == 0)
                ack_ok = (b == CH_ACK);
            rx_count = rx_count + 1'b1;
            if (rx_count >= need)
            begin
                if (!ack_ok)
                    end_job(STATUS_PROTO);
                else
                begin
                    push_word(KIND_TX, CH_ENQ, STATUS_OK);
                    if (addr_on)
                    begin
                        push_word(KIND_TX, tens_digit(station), STATUS_OK);
                        push_word(KIND_TX, ones_digit(station), STATUS_OK);
                    end
                    if (reply_len == 0)
                        end_job(STATUS_OK);
                    else
                    begin
                        link_phase = PH_REPLY;
                        rx_count   = '0;
                        frame_xor  = '0;
                    end
                end
            end
        end
        else if (link_phase == PH_REPLY)
        begin
            hdr   = addr_on ? 5 : 3;
            total = reply_len + hdr + 2;
            if (rx_count + 1 >= total)
                end_job((frame_xor == b) ? STATUS_OK : STATUS_PROTO);
            else
            begin
                frame_xor = frame_xor ^ b;
                if (rx_count >= hdr && rx_count < hdr + reply_len)
                    push_word(KIND_PAYLOAD, b, STATUS_OK);
                rx_count = rx_count + 1'b1;
            end
        end
    endfunction

    // Count a tick against the first-byte or gap limit
    function automatic void take_tick();
        logic [15:0] limit;
        if (link_phase == PH_ACK || link_phase == PH_REPLY)
        begin
            if (rx_count != 0)
                limit = gap_limit;
            else if (link_phase == PH_ACK)
                limit = ack_limit;
            else
                limit = reply_limit;
            if (tick_count != WAIT_MAX)
                tick_count = tick_count + 1'b1;
            if (tick_count >= limit)
                end_job(STATUS_TIMEOUT);
        end
    endfunction

    // Work out the words caused by one accepted input word
    function automatic void advance_link(in_word_t w);
        int        first;
        out_word_t tail;
        first = due_words.size();
        case (w.action)
            ACT_START:
                if (link_phase == PH_IDLE)
                begin
                    frame_xor = '0;
                    reply_len = w.reply_length;
                    send_byte(CH_STX);
                    if (station != NO_ADDR)
                    begin
                        send_byte(tens_digit(station));
                        send_byte(ones_digit(station));
                    end
                    send_byte(w.command_code);
                    send_byte(w.parameter_code);
                    if (w.has_body)
                    begin
                        link_phase = PH_BODY;
                        rx_count   = '0;
                        tick_count = '0;
                    end
                    else
                        close_frame();
                end
            ACT_BODY:
                if (link_phase == PH_BODY)
                begin
                    send_byte(w.data_byte);
                    if (w.body_last)
                        close_frame();
                end
            ACT_LINE:
                take_line_byte(w.data_byte);
            default:
                take_tick();
        endcase
        // Mark the last word of this input
        if (due_words.size() > first)
        begin
            tail = due_words.pop_back();
            tail.run_last = 1'b1;
            due_words.push_back(tail);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n)
        begin
            station     = NO_ADDR;
            ack_limit   = ACK_WAIT_RESET;
            reply_limit = REPLY_WAIT_RESET;
            gap_limit   = GAP_WAIT_RESET;
            link_phase  = PH_IDLE;
            frame_xor   = '0;
            rx_count    = '0;
            reply_len   = '0;
            tick_count  = '0;
            ack_ok      = 1'b0;
            due_words.delete();
            bad = 0;
        end
        else
        begin
            // Apply register writes
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_STATION_ADDRESS: station     = cfg_data[7:0];
                    REG_ACK_WAIT:        ack_limit   = cfg_data;
                    REG_REPLY_WAIT:      reply_limit = cfg_data;
                    default:             gap_limit   = cfg_data;
                endcase
            end

            // Compare each delivered word with the oldest one owed
            if (out_valid && out_ready)
            begin
                if (due_words.size() == 0)
                begin
                    bad++;
                    if (bad <= 10)
                        $display("unexpected word: kind %0d data %02h last %0b status %0d",
                                 out_word.kind, out_word.data, out_word.run_last,
                                 out_word.status);
                end
                else
                begin
                    want = due_words.pop_front();
                    if (out_word.kind !== want.kind || out_word.data !== want.data ||
                        out_word.run_last !== want.run_last ||
                        out_word.status !== want.status)
                    begin
                        bad++;
                        if (bad <= 10)
                            $display("word mismatch (kind/data/last/status): %s %0d/%02h/%0b/%0d %s %0d/%02h/%0b/%0d",
                                     "want", want.kind, want.data, want.run_last, want.status,
                                     "got", out_word.kind, out_word.data, out_word.run_last,
                                     out_word.status);
                    end
                end
            end

            if (in_valid && in_ready)
                advance_link(in_word);
        end
        mismatch_count <= bad;
        pending        <= due_words.size();
    end

endmodule

>>> tb/testbench.sv
// Testbench top: drives directed and random link traffic and reports the verdict.
module testbench;
    import scl_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    in_word_t               in_word;
    logic                   out_valid;
    logic                   out_ready;
    out_word_t              out_word;
    int                     mismatch_count;
    int                     pending;

    // Register values as last written, used to shape traffic
    logic [7:0]  cur_addr;
    logic [15:0] cur_ack;
    logic [15:0] cur_reply;
    logic [15:0] cur_gap;

    logic tx_idle  = 1'b0;
    logic rx_idle  = 1'b0;
    logic hold_req = 1'b0;
    int   items_sent = 0;

    stx_etx_bcc_command_link_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    command_link_checker link_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_word        (in_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_word       (out_word),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop for a hung run
    initial
    begin
        #10000000;
        $display("testbench failed");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin : receiver
        int n;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (150) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 6);
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Word of the given action with every other field random
    function automatic in_word_t blank_word(action_t a);
        logic [63:0] r;
        in_word_t    w;
        r = {$urandom, $urandom};
        w = r[$bits(in_word_t)-1:0];
        w.action = a;
        return w;
    endfunction

    // Offer one word, maybe after an idle burst, and hold it until taken
    task automatic put_word(input in_word_t w);
        int n;
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 6);
            repeat (n) @(posedge clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic do_start(input logic [7:0] cmd, input logic [7:0] par,
                            input logic body, input logic [7:0] rlen);
        in_word_t w;
        w = blank_word(ACT_START);
        w.command_code   = cmd;
        w.parameter_code = par;
        w.has_body       = body;
        w.reply_length   = rlen;
        items_sent++;
        put_word(w);
    endtask

    task automatic do_body(input logic [7:0] b, input logic last);
        in_word_t w;
        w = blank_word(ACT_BODY);
        w.data_byte = b;
        w.body_last = last;
        items_sent++;
        put_word(w);
    endtask

    task automatic do_line(input logic [7:0] b);
        in_word_t w;
        w = blank_word(ACT_LINE);
        w.data_byte = b;
        items_sent++;
        put_word(w);
    endtask

    task automatic do_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            items_sent++;
            put_word(blank_word(ACT_TICK));
        end
    endtask

    // Let time pass on the line: run out the limit, or stay short of it
    task automatic wait_ticks(input logic [15:0] limit, input logic expire,
                              output logic expired);
        int n;
        expired = 1'b0;
        if (expire && limit <= 40)
        begin
            do_ticks(int'(limit));
            expired = 1'b1;
        end
        else
        begin
            n = (limit > 4) ? $urandom_range(0, 3) : $urandom_range(0, int'(limit) - 1);
            do_ticks(n);
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] v);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_STATION_ADDRESS: cur_addr  = v[7:0];
            REG_ACK_WAIT:        cur_ack   = v;
            REG_REPLY_WAIT:      cur_reply = v;
            default:             cur_gap   = v;
        endcase
    endtask

    task automatic set_all(input logic [15:0] addr, input logic [15:0] ack,
                           input logic [15:0] reply, input logic [15:0] gap);
        write_reg(REG_STATION_ADDRESS, addr);
        write_reg(REG_ACK_WAIT, ack);
        write_reg(REG_REPLY_WAIT, reply);
        write_reg(REG_GAP_WAIT, gap);
    endtask

    // Drop valid and hold off until every owed word has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One command exchange; a fixed reply length rules out timeouts and a refused acknowledge
    task automatic run_job(input int len_hint);
        logic       addr_on;
        logic       expired;
        logic       has_body;
        logic       nak;
        logic [7:0] rlen;
        logic [7:0] b;
        logic [7:0] sum;
        int         expire_at;
        int         waits;
        int         nbody;
        int         need;
        int         hdr;
        int         total;

        addr_on   = (cur_addr != NO_ADDR);
        waits     = 0;
        nak       = 1'b0;
        expire_at = -1;
        if (len_hint >= 0)
            rlen = len_hint[7:0];
        else
        begin
            rlen = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
            if ($urandom_range(0, 2) == 0)
                expire_at = $urandom_range(0, 12);
        end

        // Stray words while idle are dropped
        if ($urandom_range(0, 4) == 0)
            put_word(blank_word(action_t'($urandom_range(1, 3))));

        has_body = 1'($urandom_range(0, 1));
        do_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), has_body, rlen);
        if (has_body)
        begin
            nbody = $urandom_range(0, 4);
            for (int i = 0; i < nbody; i++)
                do_body(8'($urandom_range(0, 255)), 1'b0);
            // A start while busy is dropped
            if ($urandom_range(0, 5) == 0)
                do_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            do_body(8'($urandom_range(0, 255)), 1'b1);
        end

        // Acknowledge bytes
        need = addr_on ? 3 : 1;
        for (int i = 0; i < need; i++)
        begin
            wait_ticks((i == 0) ? cur_ack : cur_gap, waits == expire_at, expired);
            waits++;
            if (expired)
                return;
            if (i == 0)
            begin
                b   = (len_hint < 0 && $urandom_range(0, 5) == 0) ?
                      8'($urandom_range(0, 255)) : CH_ACK;
                nak = (b != CH_ACK);
            end
            else
                b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
                put_word(blank_word(ACT_BODY));
            do_line(b);
        end
        if (nak || rlen == 0)
            return;

        // Reply: header, payload, ETX, check byte
        hdr   = addr_on ? 5 : 3;
        total = rlen + hdr + 2;
        sum   = '0;
        for (int i = 0; i < total; i++)
        begin
            wait_ticks((i == 0) ? cur_reply : cur_gap, waits == expire_at, expired);
            waits++;
            if (expired)
                return;
            if (i == total - 1)
                b = ($urandom_range(0, 5) == 0) ? sum ^ 8'($urandom_range(1, 255)) : sum;
            else if (i == total - 2)
                b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CH_ETX;
            else
                b = 8'($urandom_range(0, 255));
            sum = sum ^ b;
            do_line(b);
        end
    endtask

    task automatic run_random(input int target, input logic calm);
        int stop;
        stop = items_sent + target;
        while (items_sent < stop)
        begin
            tx_idle = !calm && ($urandom_range(0, 3) != 0);
            rx_idle = !calm && ($urandom_range(0, 3) != 0);
            run_job(-1);
        end
    endtask

    initial
    begin : stimulus
        int guard;

        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_word   = '0;
        cur_addr  = NO_ADDR;
        cur_ack   = ACK_WAIT_RESET;
        cur_reply = REPLY_WAIT_RESET;
        cur_gap   = GAP_WAIT_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed traffic at the reset register values
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        do_ticks(1);
        do_line(CH_ACK);
        do_body(8'hFF, 1'b1);
        do_start(8'h00, 8'hFF, 1'b1, 8'd1);
        do_start(8'hFF, 8'h00, 1'b0, 8'd0);
        do_line(8'hFF);
        do_ticks(1);
        do_body(8'hFF, 1'b0);
        do_body(8'h00, 1'b1);
        do_body(8'h55, 1'b1);
        do_ticks(1);
        do_line(CH_ACK);
        do_line(8'h00);
        do_line(8'hFF);
        do_line(8'h5A);
        do_line(8'hA5);
        do_line(CH_ETX);
        do_line(8'h00 ^ 8'hFF ^ 8'h5A ^ 8'hA5 ^ CH_ETX);
        // Refused acknowledge ends the job with a protocol error
        do_start(8'hFF, 8'h00, 1'b0, 8'd255);
        do_line(8'h15);
        // Zero reply length completes right after the enquiry
        do_start(8'h5A, 8'hA5, 1'b0, 8'd0);
        do_line(CH_ACK);
        wait_drained();

        // Lowest address and lowest limits: any tick times out
        set_all({8'hA5, 8'd0}, 16'd1, 16'd1, 16'd1);
        do_start(8'h12, 8'h34, 1'b0, 8'd2);
        do_ticks(1);
        do_start(8'h56, 8'h78, 1'b0, 8'd2);
        do_line(CH_ACK);
        do_ticks(1);
        run_random(20, 1'b0);
        wait_drained();

        // Highest address; long receiver hold-off fills the link
        set_all({8'h5A, 8'd254}, 16'd3, 16'd5, 16'd2);
        hold_req = 1'b1;
        tx_idle  = 1'b0;
        run_job(3);
        wait_drained();
        run_random(20, 1'b0);
        wait_drained();

        // Random address and limits, with one long reply
        set_all({8'($urandom_range(0, 255)), 8'($urandom_range(0, 254))},
                16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                16'($urandom_range(1, 12)));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        run_job(24);
        run_random(20, 1'b0);
        wait_drained();

        // No address bytes
        set_all({8'($urandom_range(0, 255)), NO_ADDR},
                16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                16'($urandom_range(1, 12)));
        run_random(20, 1'b0);
        wait_drained();

        // Highest limits: ticks stay far below them, a refused acknowledge ends the job
        set_all({8'($urandom_range(0, 255)), 8'($urandom_range(0, 254))},
                16'hFFFF, 16'hFFFF, 16'hFFFF);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        do_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 8'd1);
        do_ticks(8);
        do_line(8'h15);
        do_line(8'h15);
        do_line(8'h15);
        run_random(15, 1'b0);
        wait_drained();

        // Last stretch without any idling
        set_all({8'($urandom_range(0, 255)), 8'($urandom_range(0, 254))},
                16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                16'($urandom_range(1, 12)));
        run_random(25, 1'b1);

        // Drain and give the verdict
        in_valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (pending != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
